// ===== design/rlpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpf_pkg
// Shared constants and types of the RGB LED pattern fader.
// ----------------------------------------------------------------------------
`default_nettype none

package rlpf_pkg;

  localparam int MAX_ENTRIES   = 16;
  localparam int IDX_W         = $clog2(MAX_ENTRIES);
  localparam int LEN_W         = 5;
  localparam int DURATION_BITS = 16;
  localparam int COL_W         = 8;
  localparam int RAMP_W        = 16;
  localparam int DIV_W         = DURATION_BITS;
  localparam int NCH           = 3;
  localparam int CFG_IDX_W     = 2;

  // request kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH      = 2'd2;

  typedef struct packed {
    logic [COL_W-1:0]         red;
    logic [COL_W-1:0]         green;
    logic [COL_W-1:0]         blue;
    logic [DURATION_BITS-1:0] duration;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/rlpf_table.sv =====
// ----------------------------------------------------------------------------
// rlpf_table
// Pattern table: synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpf_table import rlpf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tbl_wr_t          wr,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data
);

  entry_t                 mem_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] vld_r;
  entry_t                 rd_q_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

// ===== design/rlpf_div.sv =====
// ----------------------------------------------------------------------------
// rlpf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpf_div import rlpf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] den_r;
  logic [DIV_W:0]   sh;
  logic [DIV_W:0]   sub;
  logic             ge;

  always_comb begin
    sh  = {rem_r, quo_r[DIV_W-1]};
    sub = sh - {1'b0, den_r};
    ge  = (sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      quo_r <= req.dividend;
      rem_r <= '0;
      den_r <= req.divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      rem_r <= ge ? sub[DIV_W-1:0] : sh[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ===== design/rgb_led_pattern_fader.sv =====
// ----------------------------------------------------------------------------
// rgb_led_pattern_fader
// Fades an RGB LED through a stored table of colour entries.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+--------------------
//  in      | kind entry_index red green blue duration  | in_valid / in_stall
//  out     | red/green/blue_drive entry_now running    | out_valid/out_stall
//  cfg     | index data                                | cfg_valid/cfg_ready
//
//  Ticks that do not end a ramp, table writes and unused kinds go straight to
//  the output register; a start that only holds entry 0 first does one table
//  read. An entry change is a table read, then four passes of the single
//  bit-serial divider (steps per entry, then one per colour channel); a
//  zero-step entry needs only the first pass. One request is worked on at a
//  time; the next is taken as soon as its result has gone into the output
//  register, which holds it while out_stall. Reset is synchronous, active
//  low; table entries read as zero until written.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_pattern_fader import rlpf_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_kind,
  input  wire logic [IDX_W-1:0]         in_entry_index,
  input  wire logic [COL_W-1:0]         in_red,
  input  wire logic [COL_W-1:0]         in_green,
  input  wire logic [COL_W-1:0]         in_blue,
  input  wire logic [DURATION_BITS-1:0] in_duration,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [COL_W-1:0]              out_red_drive,
  output logic [COL_W-1:0]              out_green_drive,
  output logic [COL_W-1:0]              out_blue_drive,
  output logic [IDX_W-1:0]              out_entry_now,
  output logic                          out_running,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [RAMP_W-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_STEPS,
    S_CHAN,
    S_OUT
  } state_t;

  typedef logic [NCH-1:0][COL_W-1:0] col3_t;
  typedef logic [NCH-1:0][COL_W:0]   inc3_t;

  // configuration
  logic              act_high_r, act_high_nxt;
  logic [RAMP_W-1:0] ramp_r,     ramp_nxt;
  logic [LEN_W-1:0]  len_r,      len_nxt;

  // sequencer state
  state_t               state_r,    state_nxt;
  logic                 seq_r,      seq_nxt;
  logic [IDX_W-1:0]     cur_r,      cur_nxt;
  logic [RAMP_W-1:0]    tick_r,     tick_nxt;
  logic [DIV_W-1:0]     steps_in_r, steps_in_nxt;
  logic [DIV_W-1:0]     done_r,     done_nxt;
  col3_t                shown_r,    shown_nxt;
  col3_t                target_r,   target_nxt;
  col3_t                from_r,     from_nxt;
  inc3_t                inc_r,      inc_nxt;
  logic                 hold_r,     hold_nxt;
  logic                 off_r,      off_nxt;
  logic [1:0]           chan_r,     chan_nxt;

  // output register
  logic                 ovld_r,     ovld_nxt;
  col3_t                odrv_r,     odrv_nxt;
  logic [IDX_W-1:0]     oent_r,     oent_nxt;
  logic                 orun_r,     orun_nxt;

  // table and divider
  tbl_wr_t              tbl_wr;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  entry_t               rd_data;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic                 acc_in;
  logic [RAMP_W-1:0]    eff_ramp;
  logic [LEN_W-1:0]     eff_len;
  logic                 len_le1;
  logic [RAMP_W:0]      tick_inc;
  logic [LEN_W-1:0]     nxt_idx;
  logic                 wrap;
  logic [IDX_W-1:0]     adv_idx;
  col3_t                rd_col;
  col3_t                mag;
  logic [NCH-1:0]       neg;
  logic [COL_W:0]       diff;
  logic [COL_W:0]       qinc;
  logic [1:0]           chan_up;

  rlpf_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rlpf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc_in    = in_valid && !in_stall;

  // zero ramp acts as one; lengths above the table are clipped
  assign eff_ramp = (ramp_r == '0) ? RAMP_W'(1) : ramp_r;
  assign eff_len  = (len_r > LEN_W'(MAX_ENTRIES)) ? LEN_W'(MAX_ENTRIES) : len_r;
  assign len_le1  = (eff_len <= LEN_W'(1));
  assign tick_inc = {1'b0, tick_r} + (RAMP_W + 1)'(1);
  assign nxt_idx  = LEN_W'(cur_r) + LEN_W'(1);
  assign wrap     = (nxt_idx >= eff_len);
  assign adv_idx  = (len_le1 || wrap) ? '0 : nxt_idx[IDX_W-1:0];
  assign rd_col   = {rd_data.blue, rd_data.green, rd_data.red};
  assign chan_up  = chan_r + 2'd1;

  // sign and magnitude of target minus start colour, per channel
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      diff   = {1'b0, target_r[c]} - {1'b0, from_r[c]};
      neg[c] = diff[COL_W];
      mag[c] = neg[c] ? COL_W'(-diff) : diff[COL_W-1:0];
    end
  end

  assign qinc = neg[chan_r] ? -{1'b0, div_rsp.quotient[COL_W-1:0]}
                            :  {1'b0, div_rsp.quotient[COL_W-1:0]};

  always_comb begin
    act_high_nxt = act_high_r;
    ramp_nxt     = ramp_r;
    len_nxt      = len_r;
    state_nxt    = state_r;
    seq_nxt      = seq_r;
    cur_nxt      = cur_r;
    tick_nxt     = tick_r;
    steps_in_nxt = steps_in_r;
    done_nxt     = done_r;
    shown_nxt    = shown_r;
    target_nxt   = target_r;
    from_nxt     = from_r;
    inc_nxt      = inc_r;
    hold_nxt     = hold_r;
    off_nxt      = off_r;
    chan_nxt     = chan_r;
    ovld_nxt     = ovld_r;
    odrv_nxt     = odrv_r;
    oent_nxt     = oent_r;
    orun_nxt     = orun_r;
    tbl_wr       = '0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    div_req      = '0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_ACTIVE_HIGH: act_high_nxt = cfg_data[0];
        CFG_RAMP:        ramp_nxt     = cfg_data;
        CFG_LENGTH:      len_nxt      = cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end

    if (ovld_r && !out_stall) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          state_nxt = S_OUT;
          case (in_kind)
            KIND_WRITE: begin
              tbl_wr.en   = 1'b1;
              tbl_wr.addr = in_entry_index;
              tbl_wr.data = '{red: in_red, green: in_green, blue: in_blue,
                              duration: in_duration};
            end
            KIND_START: begin
              rd_en     = 1'b1;
              state_nxt = S_RD;
              hold_nxt  = len_le1;
              off_nxt   = 1'b1;
              if (!len_le1) begin
                seq_nxt  = 1'b1;
                cur_nxt  = '0;
                tick_nxt = '0;
              end
            end
            KIND_TICK: begin
              if (seq_r) begin
                if (tick_inc < {1'b0, eff_ramp}) begin
                  tick_nxt = tick_inc[RAMP_W-1:0];
                end else begin
                  tick_nxt = '0;
                  if (done_r < steps_in_r) begin
                    for (int c = 0; c < NCH; c++) begin
                      shown_nxt[c] = shown_r[c] + inc_r[c][COL_W-1:0];
                    end
                    done_nxt = done_r + DIV_W'(1);
                  end else begin
                    // ramp finished: snap, then next entry or hold
                    shown_nxt = target_r;
                    rd_en     = 1'b1;
                    rd_addr   = adv_idx;
                    state_nxt = S_RD;
                    hold_nxt  = len_le1;
                    off_nxt   = wrap;
                    cur_nxt   = adv_idx;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_RD: begin
        if (hold_r) begin
          seq_nxt      = 1'b0;
          cur_nxt      = '0;
          shown_nxt    = rd_col;
          target_nxt   = rd_col;
          inc_nxt      = '0;
          steps_in_nxt = '0;
          done_nxt     = '0;
          tick_nxt     = '0;
          state_nxt    = S_OUT;
        end else begin
          target_nxt       = rd_col;
          from_nxt         = off_r ? '0 : target_r;
          div_req.start    = 1'b1;
          div_req.dividend = rd_data.duration;
          div_req.divisor  = eff_ramp;
          state_nxt        = S_STEPS;
        end
      end

      S_STEPS: begin
        if (div_rsp.done) begin
          steps_in_nxt = div_rsp.quotient;
          if (div_rsp.quotient == '0) begin
            // zero-step entry jumps straight to its colour
            inc_nxt   = '0;
            shown_nxt = target_r;
            done_nxt  = '0;
            state_nxt = S_OUT;
          end else begin
            chan_nxt         = '0;
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(mag[0]);
            div_req.divisor  = div_rsp.quotient;
            state_nxt        = S_CHAN;
          end
        end
      end

      S_CHAN: begin
        if (div_rsp.done) begin
          inc_nxt[chan_r]   = qinc;
          shown_nxt[chan_r] = from_r[chan_r] + qinc[COL_W-1:0];
          if (chan_r == 2'(NCH - 1)) begin
            done_nxt  = DIV_W'(1);
            state_nxt = S_OUT;
          end else begin
            chan_nxt         = chan_up;
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(mag[chan_up]);
            div_req.divisor  = steps_in_r;
            state_nxt        = S_CHAN;
          end
        end
      end

      S_OUT: begin
        if (!ovld_r || !out_stall) begin
          ovld_nxt  = 1'b1;
          odrv_nxt  = act_high_r ? shown_r : ~shown_r;
          oent_nxt  = cur_r;
          orun_nxt  = seq_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_high_r <= 1'b1;
      ramp_r     <= RAMP_W'(10);
      len_r      <= '0;
      state_r    <= S_IDLE;
      seq_r      <= 1'b0;
      cur_r      <= '0;
      tick_r     <= '0;
      steps_in_r <= '0;
      done_r     <= '0;
      shown_r    <= '0;
      target_r   <= '0;
      inc_r      <= '0;
      ovld_r     <= 1'b0;
    end else begin
      act_high_r <= act_high_nxt;
      ramp_r     <= ramp_nxt;
      len_r      <= len_nxt;
      state_r    <= state_nxt;
      seq_r      <= seq_nxt;
      cur_r      <= cur_nxt;
      tick_r     <= tick_nxt;
      steps_in_r <= steps_in_nxt;
      done_r     <= done_nxt;
      shown_r    <= shown_nxt;
      target_r   <= target_nxt;
      inc_r      <= inc_nxt;
      ovld_r     <= ovld_nxt;
    end
    from_r <= from_nxt;
    hold_r <= hold_nxt;
    off_r  <= off_nxt;
    chan_r <= chan_nxt;
    odrv_r <= odrv_nxt;
    oent_r <= oent_nxt;
    orun_r <= orun_nxt;
  end

  assign out_valid       = ovld_r;
  assign out_red_drive   = odrv_r[0];
  assign out_green_drive = odrv_r[1];
  assign out_blue_drive  = odrv_r[2];
  assign out_entry_now   = oent_r;
  assign out_running     = orun_r;

  // tick counter only runs while sequencing
  a_idle_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !seq_r |-> tick_r == '0)
    else $error("tick counter non-zero while not sequencing");

  // between requests the step count never passes the entry's step total
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> done_r <= steps_in_r)
    else $error("steps done exceeds steps in entry");

  // divider results only arrive while the sequencer waits for them
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_STEPS || state_r == S_CHAN))
    else $error("divider result outside a wait state");

  // a table read is only launched by an accepted request
  a_rd_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> $past(state_r) == S_IDLE && $past(acc_in))
    else $error("table read state entered without a request");

endmodule

`default_nettype wire

// ===== dv/tb_rgb_led_pattern_fader.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_led_pattern_fader
// Self-checking bench for the RGB LED pattern fader.
// A scoreboard class tracks table, fade and sequencing state for every
// accepted request. It compares each drive result field by field against
// the oldest prediction. A directed opener is followed by randomised
// phases of pattern set-up and millisecond ticks under bursty traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rgb_led_pattern_fader;
  import rlpf_pkg::*;

  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int DRAIN_CYCLES    = 120;   // well past one entry change
  localparam int NUM_PHASES      = 24;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int MAX_STALL_RUN   = 16;

  localparam logic [1:0] KIND_UNUSED = 2'd3;   // no request kind; must be a no-op

  // register select masks, one bit per register index
  localparam bit [2:0] SEL_ALL    = 3'b111;
  localparam bit [2:0] SEL_TIMING = (3'b1 << CFG_RAMP) | (3'b1 << CFG_LENGTH);
  localparam bit [2:0] SEL_LENGTH = 3'b1 << CFG_LENGTH;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [IDX_W-1:0]         idx;
    logic [COL_W-1:0]         red;
    logic [COL_W-1:0]         green;
    logic [COL_W-1:0]         blue;
    logic [DURATION_BITS-1:0] duration;
  } fade_req_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic [IDX_W-1:0] entry_now;
    logic             running;
  } led_drive_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the fader state, predicted drives in order
  // --------------------------------------------------------------------------
  class fade_scoreboard;
    bit                     polarity_high = 1'b1;
    bit [RAMP_W-1:0]        ramp_ms       = 16'd10;
    bit [LEN_W-1:0]         length_cfg;
    bit [COL_W-1:0]         tbl_col [MAX_ENTRIES][NCH];
    bit [DURATION_BITS-1:0] tbl_dur [MAX_ENTRIES];
    bit [COL_W-1:0]         lit  [NCH];
    bit [COL_W-1:0]         goal [NCH];
    int                     incr [NCH];
    int                     fade_steps;
    int                     steps_taken;
    int                     ms_count;
    bit [IDX_W-1:0]         cur_idx;
    bit                     sequencing;
    led_drive_t             expected_drives[$];
    int                     results_seen;
    int                     errors;

    // a ramp of zero behaves as one millisecond
    function int ramp_period();
      return (ramp_ms == 0) ? 1 : int'(ramp_ms);
    endfunction

    // lengths beyond the table are clamped to the table size
    function int used_length();
      return (length_cfg > MAX_ENTRIES) ? MAX_ENTRIES : int'(length_cfg);
    endfunction

    function void show_first_entry();
      sequencing  = 1'b0;
      cur_idx     = '0;
      foreach (lit[c]) begin
        lit[c]  = tbl_col[0][c];
        goal[c] = tbl_col[0][c];
        incr[c] = 0;
      end
      fade_steps  = 0;
      steps_taken = 0;
      ms_count    = 0;
    endfunction

    function void enter_entry(int idx, bit from_off);
      bit [COL_W-1:0] from [NCH];
      cur_idx    = IDX_W'(idx % MAX_ENTRIES);
      ms_count   = 0;
      fade_steps = tbl_dur[cur_idx] / ramp_period();
      foreach (from[c]) begin
        from[c] = from_off ? '0 : goal[c];
        goal[c] = tbl_col[cur_idx][c];
      end
      if (fade_steps == 0) begin
        // zero-step entry: jump straight to the colour, no division
        foreach (lit[c]) begin
          incr[c] = 0;
          lit[c]  = goal[c];
        end
        steps_taken = 0;
      end else begin
        // signed int division truncates toward zero; first step applied now
        foreach (lit[c]) begin
          incr[c] = (int'(goal[c]) - int'(from[c])) / fade_steps;
          lit[c]  = COL_W'(int'(from[c]) + incr[c]);
        end
        steps_taken = 1;
      end
    endfunction

    function void restart_sequence();
      if (used_length() <= 1) begin
        show_first_entry();
      end else begin
        sequencing = 1'b1;
        enter_entry(0, 1'b1);
      end
    endfunction

    function void advance_ms();
      int nxt;
      if (!sequencing) return;
      ms_count++;
      if (ms_count < ramp_period()) return;
      ms_count = 0;
      if (steps_taken < fade_steps) begin
        foreach (lit[c]) lit[c] = COL_W'(int'(lit[c]) + incr[c]);
        steps_taken++;
        return;
      end
      lit = goal;
      if (used_length() <= 1) begin
        show_first_entry();
        return;
      end
      nxt = int'(cur_idx) + 1;
      if (nxt >= used_length()) enter_entry(0, 1'b1);
      else enter_entry(nxt, 1'b0);
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [RAMP_W-1:0] value);
      case (idx)
        CFG_ACTIVE_HIGH: polarity_high = value[0];
        CFG_RAMP:        ramp_ms       = value;
        CFG_LENGTH:      length_cfg    = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(fade_req_t rq);
      led_drive_t drv;
      case (rq.kind)
        KIND_TICK:  advance_ms();
        KIND_WRITE: begin
          tbl_col[rq.idx][0] = rq.red;
          tbl_col[rq.idx][1] = rq.green;
          tbl_col[rq.idx][2] = rq.blue;
          tbl_dur[rq.idx]    = rq.duration;
        end
        KIND_START: restart_sequence();
        default: ;
      endcase
      // active-low drive is 255 minus the level, i.e. the bitwise inverse
      drv.red       = polarity_high ? lit[0] : ~lit[0];
      drv.green     = polarity_high ? lit[1] : ~lit[1];
      drv.blue      = polarity_high ? lit[2] : ~lit[2];
      drv.entry_now = cur_idx;
      drv.running   = sequencing;
      expected_drives.push_back(drv);
    endfunction

    task report_mismatch(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 40)
        $display("[%0t] result %0d: %s expected 0x%0h got 0x%0h",
                 $realtime, results_seen, what, want, got);
    endtask

    task check_drive(led_drive_t got);
      led_drive_t want;
      results_seen++;
      if (expected_drives.size() == 0) begin
        report_mismatch("result without request", 0, got);
        return;
      end
      want = expected_drives.pop_front();
      if (got.red !== want.red)             report_mismatch("red_drive", want.red, got.red);
      if (got.green !== want.green)         report_mismatch("green_drive", want.green, got.green);
      if (got.blue !== want.blue)           report_mismatch("blue_drive", want.blue, got.blue);
      if (got.entry_now !== want.entry_now) report_mismatch("entry_now", want.entry_now,
                                                            got.entry_now);
      if (got.running !== want.running)     report_mismatch("running", want.running, got.running);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block I/O
  // --------------------------------------------------------------------------
  logic                     clk;
  logic                     rst_n           = 1'b0;
  logic                     in_valid        = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_kind         = KIND_TICK;
  logic [IDX_W-1:0]         in_entry_index  = '0;
  logic [COL_W-1:0]         in_red          = '0;
  logic [COL_W-1:0]         in_green        = '0;
  logic [COL_W-1:0]         in_blue         = '0;
  logic [DURATION_BITS-1:0] in_duration     = '0;
  logic                     out_valid;
  logic                     out_stall       = 1'b0;
  logic [COL_W-1:0]         out_red_drive;
  logic [COL_W-1:0]         out_green_drive;
  logic [COL_W-1:0]         out_blue_drive;
  logic [IDX_W-1:0]         out_entry_now;
  logic                     out_running;
  logic                     cfg_valid       = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index       = CFG_ACTIVE_HIGH;
  logic [RAMP_W-1:0]        cfg_data        = '0;

  fade_scoreboard board = new();

  int burst_left = 0;   // requests left in the current sender burst
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  rgb_led_pattern_fader u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_entry_index  (in_entry_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_duration     (in_duration),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red_drive   (out_red_drive),
    .out_green_drive (out_green_drive),
    .out_blue_drive  (out_blue_drive),
    .out_entry_now   (out_entry_now),
    .out_running     (out_running),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Watchdog: ends a hung or dropped-result run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: samples results at the edge, then picks the next stall value.
  // Stall behaviour switches between modes at random intervals, and a
  // stall run is capped so a single result never waits too long.
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          stall_run  = 0;
  logic        want_stall;
  led_drive_t  seen;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_red_drive, out_green_drive, out_blue_drive, out_entry_now, out_running};
      board.check_drive(seen);
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(32, 400);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE:  want_stall = 1'b0;
      STALL_LIGHT: want_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: want_stall = ($urandom_range(0, 3) != 0);
      default:     want_stall = ((cycle_count % 7) < 3);
    endcase
    if (stall_run >= MAX_STALL_RUN) want_stall = 1'b0;
    stall_run = want_stall ? stall_run + 1 : 0;
    out_stall <= want_stall;
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Present one request and hold it until taken. Valid stays high across a
  // burst; after a burst the line drops for a random gap, sometimes long
  // enough to cover a whole entry change.
  task automatic push_request(fade_req_t rq);
    int gap;
    in_valid       <= 1'b1;
    in_kind        <= rq.kind;
    in_entry_index <= rq.idx;
    in_red         <= rq.red;
    in_green       <= rq.green;
    in_blue        <= rq.blue;
    in_duration    <= rq.duration;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(rq);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every predicted result is back, then let the block settle.
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_drives.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Valid is left high so back-to-back writes do not toggle it in one step.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [RAMP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.note_config(idx, value);
  endtask

  // Registers only change with the block idle and nothing outstanding.
  task automatic configure(bit [2:0] sel, bit pol, logic [RAMP_W-1:0] ramp,
                           logic [LEN_W-1:0] len);
    wait_drained();
    if (sel[CFG_ACTIVE_HIGH]) set_reg(CFG_ACTIVE_HIGH, RAMP_W'(pol));
    if (sel[CFG_RAMP])        set_reg(CFG_RAMP, ramp);
    if (sel[CFG_LENGTH])      set_reg(CFG_LENGTH, RAMP_W'(len));
    if (sel != 0) cfg_valid <= 1'b0;
  endtask

  function automatic fade_req_t mk_req(logic [1:0] kind, logic [IDX_W-1:0] idx,
                                       logic [COL_W-1:0] r, logic [COL_W-1:0] g,
                                       logic [COL_W-1:0] b,
                                       logic [DURATION_BITS-1:0] dur);
    fade_req_t rq;
    rq.kind     = kind;
    rq.idx      = idx;
    rq.red      = r;
    rq.green    = g;
    rq.blue     = b;
    rq.duration = dur;
    return rq;
  endfunction

  // colour levels lean on the rails
  function automatic logic [COL_W-1:0] pick_level();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return COL_W'($urandom_range(0, 255));
  endfunction

  // Durations mostly give a handful of fade steps at the current ramp, with
  // some zero-step entries and the odd long or full-range one.
  function automatic fade_req_t rand_req(logic [1:0] kind, logic [IDX_W-1:0] idx);
    int rp;
    int roll;
    logic [DURATION_BITS-1:0] dur;
    rp   = board.ramp_period();
    if (rp > 8) rp = 8;
    roll = $urandom_range(0, 99);
    if (roll < 15)      dur = '0;
    else if (roll < 88) dur = DURATION_BITS'($urandom_range(1, 6 * rp));
    else if (roll < 96) dur = DURATION_BITS'($urandom_range(6 * rp, 300));
    else                dur = DURATION_BITS'($urandom);
    return mk_req(kind, idx, pick_level(), pick_level(), pick_level(), dur);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int        sent;
    int        roll;
    fade_req_t rq;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // -- directed: reset settings (active high, ramp 10, length 0) --
    push_request(mk_req(KIND_TICK, '0, '0, '0, '0, '0));            // tick while idle
    push_request(mk_req(KIND_UNUSED, '1, '1, '1, '1, '1));          // unused kind
    push_request(mk_req(KIND_START, '0, '0, '0, '0, '0));           // short pattern
    push_request(mk_req(KIND_WRITE, 4'd0, 8'hFF, 8'h00, 8'h80, 16'd0));
    push_request(mk_req(KIND_WRITE, 4'd15, 8'h00, 8'hFF, 8'h7F, 16'hFFFF));
    push_request(mk_req(KIND_WRITE, 4'd1, 8'h12, 8'h34, 8'h56, 16'd20));
    push_request(mk_req(KIND_WRITE, 4'd2, 8'hFF, 8'hFF, 8'hFF, 16'd5));
    push_request(mk_req(KIND_START, '0, '0, '0, '0, '0));           // holds entry 0

    // zero ramp, active low, three entries
    configure(SEL_ALL, 1'b0, '0, 5'd3);
    push_request(mk_req(KIND_START, '0, '0, '0, '0, '0));           // zero-step jump
    repeat (3) push_request(mk_req(KIND_TICK, '0, '0, '0, '0, '0)); // fade into entry 1
    push_request(mk_req(KIND_WRITE, 4'd2, 8'h00, 8'h00, 8'h00, 16'd1)); // write in use
    repeat (3) push_request(mk_req(KIND_TICK, '0, '0, '0, '0, '0));
    push_request(mk_req(KIND_START, '0, '0, '0, '0, '0));           // restart mid-run
    push_request(mk_req(KIND_TICK, '0, '0, '0, '0, '0));

    // longest ramp, length past the table size
    configure(SEL_ALL, 1'b1, 16'hFFFF, 5'd31);
    push_request(mk_req(KIND_START, '0, '0, '0, '0, '0));
    repeat (2) push_request(mk_req(KIND_TICK, '0, '0, '0, '0, '0));

    // length drops to one while sequencing: next advance holds entry 0
    configure(SEL_TIMING, 1'b1, 16'd1, 5'd1);
    repeat (2) push_request(mk_req(KIND_TICK, '0, '0, '0, '0, '0));

    // -- random phases: load a pattern, start it, then mostly ticks --
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      sent = 0;
      case (ph % 6)
        0: configure(SEL_ALL, 1'($urandom), 16'd1, LEN_W'($urandom_range(2, 6)));
        1: configure(SEL_TIMING, 1'b0, RAMP_W'($urandom_range(2, 4)),
                     LEN_W'($urandom_range(2, 16)));
        2: configure(SEL_ALL, 1'($urandom), (ph % 12 == 8) ? 16'hFFFF : 16'd0,
                     (ph % 12 == 8) ? 5'd31 : 5'd16);
        3: configure(SEL_LENGTH, 1'b0, '0, LEN_W'($urandom_range(0, 3)));
        4: configure(SEL_ALL, 1'($urandom), RAMP_W'($urandom_range(1, 8)),
                     LEN_W'($urandom_range(17, 31)));
        // length change under a running pattern, no reload
        default: configure(SEL_LENGTH, 1'b0, '0, LEN_W'($urandom_range(2, 5)));
      endcase

      if (ph % 6 != 5) begin
        for (int e = 0; e < board.used_length() || e < 2; e++) begin
          push_request(rand_req(KIND_WRITE, IDX_W'(e)));
          sent++;
        end
        push_request(rand_req(KIND_START, IDX_W'($urandom)));
        sent++;
      end

      // ticks with some noise: stray writes, restarts and unused kinds
      while (sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 82)      rq = rand_req(KIND_TICK, IDX_W'($urandom));
        else if (roll < 90) rq = rand_req(KIND_WRITE, IDX_W'($urandom));
        else if (roll < 94) rq = rand_req(KIND_START, IDX_W'($urandom));
        else if (roll < 97) rq = rand_req(KIND_UNUSED, IDX_W'($urandom));
        else                rq = rand_req(KIND_TICK, IDX_W'($urandom));
        push_request(rq);
        sent++;
      end
    end

    wait_drained();
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
